[hw/rtl/assert_macros.svh]
// assertion macros shared by the crossfade rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define DCF_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/dcf_pkg.sv]
// shared types, constants and the raised-cosine weight table for the crossfade
package dcf_pkg;

	// sample and state widths
	localparam int SAMPLE_BITS  = 24;
	localparam int PHASE_BITS   = 24;
	localparam int ELAPSED_BITS = 25;
	localparam int PRIME_BITS   = 24;
	localparam int FADE_BITS    = 16;
	localparam int WEIGHT_BITS  = 17;
	localparam int WT_DEPTH     = 1024;
	localparam int WT_IDX_W     = $clog2(WT_DEPTH);

	localparam logic [WEIGHT_BITS-1:0]  WEIGHT_ZERO = '0;
	localparam logic [WEIGHT_BITS-1:0]  WEIGHT_ONE  = WEIGHT_BITS'(1) << (WEIGHT_BITS - 1);
	localparam logic [PHASE_BITS-1:0]   PHASE_MAX   = '1;
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

	// apb register map
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_PRIME = 2'd0,
		REG_FADE  = 2'd1,
		REG_STEP  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PRIME_BITS-1:0] prime_frames;
		logic [FADE_BITS-1:0]  fade_frames;
		logic [PHASE_BITS-1:0] phase_step;
	} cfg_t;

	// fixed point constants of the table build
	localparam longint Q30_ONE = 64'sd1 << 30;
	localparam longint PI_Q30  = 64'sd3373259426;

	// series divisors q30 * (2k)(2k-1), highest term first
	localparam longint TAYLOR_D7 = Q30_ONE * 182;
	localparam longint TAYLOR_D6 = Q30_ONE * 132;
	localparam longint TAYLOR_D5 = Q30_ONE * 90;
	localparam longint TAYLOR_D4 = Q30_ONE * 56;
	localparam longint TAYLOR_D3 = Q30_ONE * 30;
	localparam longint TAYLOR_D2 = Q30_ONE * 12;
	localparam longint TAYLOR_D1 = Q30_ONE * 2;

	typedef logic [WEIGHT_BITS-1:0] weight_tab_t [WT_DEPTH];

	// cosine in q2.30 over a quarter turn, horner form of the taylor series
	function automatic longint cos_q30(longint x);
		longint x2;
		longint t;
		x2 = (x * x) >>> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (x2 * t) / TAYLOR_D7;
		t  = Q30_ONE - (x2 * t) / TAYLOR_D6;
		t  = Q30_ONE - (x2 * t) / TAYLOR_D5;
		t  = Q30_ONE - (x2 * t) / TAYLOR_D4;
		t  = Q30_ONE - (x2 * t) / TAYLOR_D3;
		t  = Q30_ONE - (x2 * t) / TAYLOR_D2;
		t  = Q30_ONE - (x2 * t) / TAYLOR_D1;
		return t;
	endfunction

	// 0.5 - 0.5*cos(pi*i/depth) rounded to q1.16
	function automatic longint half_weight(longint i);
		longint x;
		longint d;
		x = (PI_Q30 * i) >>> WT_IDX_W;
		d = Q30_ONE - cos_q30(x);
		if (d < 0) begin
			d = 0;
		end
		return (d + (64'sd1 << 14)) >>> 15;
	endfunction

	// upper half mirrors the lower half around one half
	function automatic weight_tab_t build_weights();
		weight_tab_t tab;
		longint      v;
		for (int i = 0; i < WT_DEPTH; i++) begin
			if (2 * i <= WT_DEPTH) begin
				v = half_weight(longint'(i));
			end else begin
				v = 64'sd65536 - half_weight(longint'(WT_DEPTH - i));
			end
			tab[i] = v[WEIGHT_BITS-1:0];
		end
		return tab;
	endfunction

	localparam weight_tab_t WEIGHT_TABLE = build_weights();

endpackage

[hw/rtl/dcf_regs.sv]
// apb configuration registers of the crossfade
module dcf_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dcf_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [dcf_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [dcf_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output dcf_pkg::cfg_t                    cfg
);
	import dcf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prime_frames <= '0;
			cfg_q.fade_frames  <= FADE_BITS'(1);
			cfg_q.phase_step   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PRIME: cfg_q.prime_frames <= pwdata[PRIME_BITS-1:0];
				REG_FADE:  cfg_q.fade_frames  <= pwdata[FADE_BITS-1:0];
				REG_STEP:  cfg_q.phase_step   <= pwdata[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_PRIME: prdata = CFG_DATA_W'(cfg_q.prime_frames);
			REG_FADE:  prdata = CFG_DATA_W'(cfg_q.fade_frames);
			REG_STEP:  prdata = CFG_DATA_W'(cfg_q.phase_step);
			default:   prdata = '0;
		endcase
	end

endmodule

[hw/rtl/dcf_mix.sv]
// weighted blend of old and new sample with round to nearest
module dcf_mix (
	input  logic signed [dcf_pkg::SAMPLE_BITS-1:0] new_sample,
	input  logic signed [dcf_pkg::SAMPLE_BITS-1:0] old_sample,
	input  logic                                   old_present,
	input  logic        [dcf_pkg::WEIGHT_BITS-1:0] weight,
	output logic signed [dcf_pkg::SAMPLE_BITS-1:0] mixed_sample
);
	import dcf_pkg::*;

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + WEIGHT_BITS + 1;
	localparam int FRAC_W = WEIGHT_BITS - 1;
	localparam int Q_W    = PROD_W - FRAC_W;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rnd;
	logic signed [Q_W-1:0]    step;
	logic signed [Q_W-1:0]    sum;

	// old + floor((new - old) * w / 2^16 + 1/2)
	always_comb begin
		diff = DIFF_W'(new_sample) - DIFF_W'(old_sample);
		prod = PROD_W'(diff) * $signed({1'b0, weight});
		rnd  = prod + (PROD_W'(1) <<< (FRAC_W - 1));
		step = rnd[PROD_W-1:FRAC_W];
		sum  = Q_W'(old_sample) + step;
	end

	// a missing old stream passes the new sample
	assign mixed_sample = old_present ? sum[SAMPLE_BITS-1:0] : new_sample;

endmodule

[hw/rtl/delayed_raised_cosine_crossfade_top.sv]
// top level of the delayed raised-cosine crossfade
//
// Each input item on the s_axis channel carries one channel sample of the
// outgoing and the incoming stream; tlast marks the last channel of a frame
// and advances the frame counter. One result item leaves on m_axis for every
// input item, in order. The first prime_frames frames play the old stream,
// the next fade_frames frames blend in the new one with a raised-cosine
// weight from a 1024-entry table, after that the new stream passes alone.
// Throughput is one item per clock while m_axis_tready is high; the weight
// and counter update are done on acceptance, the multiply between the input
// register and the output register, so a result passes both registers before
// it shows on m_axis_tvalid (two register stages in all).
// When m_axis_tready is low the output register holds and the input register
// fills; s_axis_tready drops only when both are full, so no item is lost.
// Reset clears both counters and loads prime 0, fade 1, step 0. Registers
// sit on the apb port at byte addresses 0, 4 and 8; the user must write them
// only while no item is in flight, which the block itself does not enforce.
`include "assert_macros.svh"

module delayed_raised_cosine_crossfade_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// new_sample [23:0], old_sample [47:24]
	input  logic [2*dcf_pkg::SAMPLE_BITS-1:0]      s_axis_tdata,
	// old_present
	input  logic                                   s_axis_tuser,
	input  logic                                   s_axis_tlast,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// mixed_sample [23:0]
	output logic [dcf_pkg::SAMPLE_BITS-1:0]        m_axis_tdata,
	// crossing_done
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [dcf_pkg::CFG_ADDR_W-1:0]         paddr,
	input  logic [dcf_pkg::CFG_DATA_W-1:0]         pwdata,
	output logic [dcf_pkg::CFG_DATA_W-1:0]         prdata,
	output logic                                   pready
);
	import dcf_pkg::*;

	cfg_t cfg;

	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [PHASE_BITS-1:0]   phase_q;

	logic                    in_acc;
	logic                    adv_out;
	logic [FADE_BITS-1:0]    fade_eff;
	logic [ELAPSED_BITS-1:0] fade_end;
	logic                    before_prime;
	logic                    fading;
	logic [WEIGHT_BITS-1:0]  weight;
	logic [PHASE_BITS:0]     phase_sum;
	logic [ELAPSED_BITS-1:0] elapsed_nxt;
	logic                    done;

	logic                    valid_s1;
	logic [SAMPLE_BITS-1:0]  new_s1;
	logic [SAMPLE_BITS-1:0]  old_s1;
	logic                    present_s1;
	logic [WEIGHT_BITS-1:0]  weight_s1;
	logic                    done_s1;

	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  mixed_q;
	logic                    done_q;
	logic [SAMPLE_BITS-1:0]  mixed;

	dcf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign adv_out       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_out;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// fade window and weight from the state before this item
	always_comb begin
		fade_eff     = (cfg.fade_frames == '0) ? FADE_BITS'(1) : cfg.fade_frames;
		fade_end     = ELAPSED_BITS'(cfg.prime_frames) + ELAPSED_BITS'(fade_eff);
		before_prime = elapsed_q < ELAPSED_BITS'(cfg.prime_frames);
		fading       = !before_prime && (elapsed_q < fade_end);
		if (before_prime) begin
			weight = WEIGHT_ZERO;
		end else if (fading) begin
			weight = WEIGHT_TABLE[phase_q[PHASE_BITS-1 -: WT_IDX_W]];
		end else begin
			weight = WEIGHT_ONE;
		end
		phase_sum = {1'b0, phase_q} + {1'b0, cfg.phase_step};
		if (s_axis_tlast && (elapsed_q != ELAPSED_MAX)) begin
			elapsed_nxt = elapsed_q + ELAPSED_BITS'(1);
		end else begin
			elapsed_nxt = elapsed_q;
		end
		done = elapsed_nxt >= fade_end;
	end

	// frame counter and saturating phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			phase_q   <= '0;
		end else if (in_acc) begin
			elapsed_q <= elapsed_nxt;
			if (s_axis_tlast && fading) begin
				phase_q <= phase_sum[PHASE_BITS] ? PHASE_MAX : phase_sum[PHASE_BITS-1:0];
			end
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_out) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_s1     <= s_axis_tdata[SAMPLE_BITS-1:0];
			old_s1     <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			present_s1 <= s_axis_tuser;
			weight_s1  <= weight;
			done_s1    <= done;
		end
	end

	dcf_mix u_mix (
		.new_sample   (new_s1),
		.old_sample   (old_s1),
		.old_present  (present_s1),
		.weight       (weight_s1),
		.mixed_sample (mixed)
	);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			mixed_q <= mixed;
			done_q  <= done_s1;
		end
	end

	assign m_axis_tdata  = mixed_q;
	assign m_axis_tuser  = done_q;
	assign m_axis_tvalid = out_valid_q;

	// checks
	`DCF_ASSERT_NEXT(a_phase_hold, in_acc && !fading, phase_q == $past(phase_q), "phase moved outside fade")
	`DCF_ASSERT_ALWAYS(a_elapsed_mono, elapsed_q >= $past(elapsed_q), "frame counter went back")
	`DCF_ASSERT_NEXT(a_full_pass, adv_out && valid_s1 && (weight_s1 == WEIGHT_ONE), mixed_q == $past(new_s1), "full weight does not pass new sample")

endmodule

[tb/tb.sv]
// self-checking testbench for the delayed raised-cosine crossfade: stream items, apb setup, predictor
module tb;

	localparam int LUT_DEPTH = 1024;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_SLACK = 8;
	localparam int FADE_ROUNDS = 13;
	localparam int unsigned PHASE_BUDGET = 32'd16777216;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
	localparam logic [23:0] PHASE_FULL = 24'hFFFFFF;

	typedef struct {
		logic signed [23:0] new_s;
		logic signed [23:0] old_s;
		logic               old_present;
		logic               end_of_frame;
	} sample_item_t;

	typedef struct {
		logic [23:0] mixed;
		logic        done;
	} mix_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	// new_sample [23:0], old_sample [47:24]
	logic [2*dcf_pkg::SAMPLE_BITS-1:0] s_axis_tdata = '0;
	// old_present
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// mixed_sample [23:0]
	logic [dcf_pkg::SAMPLE_BITS-1:0] m_axis_tdata;
	// crossing_done
	logic m_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [dcf_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [dcf_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [dcf_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;

	// predictor state and register copies
	int unsigned weight_lut [LUT_DEPTH];
	logic [24:0] frames_done = '0;
	logic [23:0] fade_acc = '0;
	logic [23:0] cfg_prime = '0;
	logic [15:0] cfg_fade = 16'd1;
	logic [23:0] cfg_step = '0;
	mix_result_t pending_mix [$];

	int mismatches = 0;
	int results_checked = 0;
	int items_sent = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int rx_hold_cycles = 0;
	int rx_stretch = 0;
	int unsigned rx_tick = 0;
	rx_pattern_t rx_mode = RX_OPEN;
	int unsigned cycle_count = 0;

	delayed_raised_cosine_crossfade_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// 0.5 - 0.5*cos(pi*idx/depth) in q1.16, cosine from a q2.30 taylor series
	function automatic longint cosine_half_q16(int idx);
		longint ang;
		longint ang_sq;
		longint series;
		longint gap;
		ang = (PI_Q30 * longint'(idx)) / LUT_DEPTH;
		ang_sq = (ang * ang) / ONE_Q30;
		series = ONE_Q30;
		// horner form, highest term first
		for (int k = 7; k >= 1; k--)
			series = ONE_Q30 - (ang_sq * series) / (ONE_Q30 * longint'((2 * k) * (2 * k - 1)));
		gap = ONE_Q30 - series;
		if (gap < 0)
			gap = 0;
		return (gap + 64'sd16384) / 64'sd32768;
	endfunction

	// first frame index past the fade, a zero fade length counts as one
	function automatic int unsigned fade_span_end();
		return cfg_prime + ((cfg_fade == 16'd0) ? 32'd1 : 32'(cfg_fade));
	endfunction

	// weight for the current frame position
	function automatic int unsigned current_weight();
		if (frames_done < cfg_prime)
			return 0;
		if (frames_done < fade_span_end())
			return weight_lut[fade_acc[23:14]];
		return 65536;
	endfunction

	// mixes one item and advances the frame and phase counters
	function automatic mix_result_t predict_crossfade(sample_item_t it);
		mix_result_t res;
		longint nv;
		longint ov;
		longint blend;
		logic [24:0] phase_sum;
		logic fading;
		fading = (frames_done >= cfg_prime) && (frames_done < fade_span_end());
		nv = it.new_s;
		ov = it.old_s;
		// arithmetic shift floors, so ties round toward plus infinity
		if (it.old_present)
			blend = ov + (((nv - ov) * longint'(current_weight()) + 64'sd32768) >>> 16);
		else
			blend = nv;
		if (it.end_of_frame) begin
			if (fading) begin
				phase_sum = {1'b0, fade_acc} + {1'b0, cfg_step};
				fade_acc = phase_sum[24] ? PHASE_FULL : phase_sum[23:0];
			end
			// saturates at the top, far beyond what this run reaches
			if (frames_done != '1)
				frames_done = frames_done + 25'd1;
		end
		res.mixed = blend[23:0];
		res.done = (frames_done >= fade_span_end());
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h got %0h", what, want_v, got_v);
	endtask

	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(0, 15))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return 24'sd0;
			3: return -24'sd1;
			default: return 24'($urandom);
		endcase
	endfunction

	// sends one item; entered and left at a falling edge, valid stays up inside a burst
	task automatic send_item(input logic signed [23:0] nv, input logic signed [23:0] ov,
			input logic present, input logic eof);
		sample_item_t it;
		it = '{nv, ov, present, eof};
		s_axis_tdata = {ov, nv};
		s_axis_tuser = present;
		s_axis_tlast = eof;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_mix.push_back(predict_crossfade(it));
		items_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
		end
	endtask

	// one frame of random channels, now and then an unusually long one
	task automatic send_random_frame();
		int unsigned channels;
		channels = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
		for (int c = 0; c < channels; c++)
			send_item(pick_sample(), pick_sample(), $urandom_range(0, 7) != 0, c == channels - 1);
	endtask

	// stop offering items until every result has come back
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending_mix.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// apb write, then read back where the index exists
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] stored;
		logic [31:0] readback;
		wait_drained();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		reg_writes++;
		stored = '0;
		case (idx)
			dcf_pkg::REG_PRIME: begin
				cfg_prime = value[23:0];
				stored = {8'h00, cfg_prime};
			end
			dcf_pkg::REG_FADE: begin
				cfg_fade = value[15:0];
				stored = {16'h0000, cfg_fade};
			end
			dcf_pkg::REG_STEP: begin
				cfg_step = value[23:0];
				stored = {8'h00, cfg_step};
			end
			default: ;
		endcase
		if (idx != REG_SPARE) begin
			@(negedge clk);
			psel = 1'b1;
			paddr = {idx, 2'b00};
			@(negedge clk);
			penable = 1'b1;
			@(posedge clk);
			readback = prdata;
			@(negedge clk);
			psel = 1'b0;
			penable = 1'b0;
			if (readback !== stored)
				report_mismatch("register readback", stored, readback);
		end
	endtask

	// reset registers: the first frame fades at weight zero, then the new stream passes
	task automatic test_reset_defaults();
		send_item(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0);
		send_item(SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b0);
		send_item(24'sd0, -24'sd1, 1'b0, 1'b0);
		send_item(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b1);
		send_item(SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b0);
		send_item(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0);
		send_item(24'sd123456, -24'sd5, 1'b0, 1'b1);
		send_item(-24'sd1, 24'sd0, 1'b1, 1'b1);
	endtask

	// spare index, zero fade length, a partial phase and rounding ties
	task automatic test_register_port();
		int tie_d;
		int unsigned shifted;
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		write_reg(dcf_pkg::REG_PRIME, 32'(frames_done) + 32'd1);
		write_reg(dcf_pkg::REG_FADE, 32'd0);
		write_reg(dcf_pkg::REG_STEP, 32'd262144);
		send_item(pick_sample(), pick_sample(), 1'b1, 1'b1);
		send_item(pick_sample(), pick_sample(), 1'b1, 1'b0);
		send_item(pick_sample(), pick_sample(), 1'b1, 1'b1);
		// hold the weight reached by the partial phase and hit exact half-lsb products
		write_reg(dcf_pkg::REG_PRIME, 32'(frames_done));
		write_reg(dcf_pkg::REG_FADE, 32'd3);
		write_reg(dcf_pkg::REG_STEP, 32'd0);
		tie_d = 32768;
		shifted = current_weight();
		while (shifted != 0 && shifted[0] == 1'b0 && tie_d > 1) begin
			shifted = shifted >> 1;
			tie_d = tie_d >> 1;
		end
		send_item(24'(1000 + tie_d), 24'sd1000, 1'b1, 1'b0);
		send_item(24'(1000 - tie_d), 24'sd1000, 1'b1, 1'b0);
		send_item(24'(tie_d), 24'sd0, 1'b1, 1'b0);
		send_item(24'(-tie_d), 24'sd0, 1'b1, 1'b0);
		send_item(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0);
		send_item(SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b1);
		repeat (3) send_random_frame();
	endtask

	// repeated crossfades, each primed from the current frame position
	task automatic test_fade_rounds();
		int unsigned span;
		int unsigned step;
		int unsigned lead;
		for (int r = 0; r < FADE_ROUNDS; r++) begin
			lead = $urandom_range(0, 6);
			span = $urandom_range(0, 48);
			if (r == 0)
				step = 0;
			else
				step = (PHASE_BUDGET / ((span == 0) ? 1 : span)) * $urandom_range(50, 150) / 100;
			write_reg(dcf_pkg::REG_PRIME, 32'(frames_done) + lead);
			write_reg(dcf_pkg::REG_FADE, span);
			write_reg(dcf_pkg::REG_STEP, step);
			repeat (lead + span + $urandom_range(2, 6)) send_random_frame();
		end
	endtask

	// long receiver hold while items keep coming, then a full drain
	task automatic test_backpressure();
		write_reg(dcf_pkg::REG_PRIME, 32'(frames_done) + 32'd1);
		write_reg(dcf_pkg::REG_FADE, 32'd20);
		write_reg(dcf_pkg::REG_STEP, 32'd16384);
		rx_hold_cycles = 300;
		burst_left = 10000;
		repeat (24) send_random_frame();
		burst_left = 0;
		wait_drained();
	endtask

	// largest register values, phase saturation and a fade already past
	task automatic test_register_extremes();
		write_reg(dcf_pkg::REG_PRIME, 32'h00FF_FFFF);
		write_reg(dcf_pkg::REG_FADE, 32'h0000_FFFF);
		write_reg(dcf_pkg::REG_STEP, 32'h00FF_FFFF);
		repeat (3) send_random_frame();
		write_reg(dcf_pkg::REG_PRIME, 32'd0);
		repeat (4) send_random_frame();
		write_reg(dcf_pkg::REG_FADE, 32'd1);
		repeat (3) send_random_frame();
		write_reg(dcf_pkg::REG_STEP, 32'd0);
	endtask

	// receiver: long holds on request, otherwise changing stall patterns
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles--;
			m_axis_tready = 1'b0;
		end else begin
			if (rx_stretch == 0) begin
				rx_mode = rx_pattern_t'($urandom_range(0, 3));
				rx_stretch = $urandom_range(20, 120);
			end
			rx_stretch--;
			case (rx_mode)
				RX_OPEN: m_axis_tready = 1'b1;
				RX_COIN: m_axis_tready = 1'($urandom_range(0, 1));
				RX_SPARSE: m_axis_tready = (rx_tick % 4 == 0);
				default: m_axis_tready = ($urandom_range(0, 7) != 0);
			endcase
			rx_tick++;
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		mix_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			if (pending_mix.size() == 0) begin
				report_mismatch("result with none pending", '0, m_axis_tdata);
			end else begin
				want = pending_mix.pop_front();
				if (m_axis_tdata !== want.mixed)
					report_mismatch("mixed_sample", want.mixed, m_axis_tdata);
				if (m_axis_tuser !== want.done)
					report_mismatch("crossing_done", want.done, m_axis_tuser);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < LUT_DEPTH; i++)
			weight_lut[i] = (2 * i <= LUT_DEPTH) ? int'(cosine_half_q16(i))
				: 65536 - int'(cosine_half_q16(LUT_DEPTH - i));
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_register_port();
		test_fade_rounds();
		test_backpressure();
		test_register_extremes();
		wait_drained();
		repeat (DRAIN_SLACK) @(posedge clk);
		$display("crossfade run: %0d items sent, %0d results checked, %0d frames counted",
			items_sent, results_checked, frames_done);
		$display("%0d register writes, fade phase ended at %06h, %0d mismatches",
			reg_writes, fade_acc, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/dcf_pkg.sv
hw/rtl/dcf_regs.sv
hw/rtl/dcf_mix.sv
hw/rtl/delayed_raised_cosine_crossfade_top.sv
tb/tb.sv
